// ===== hdl/srmv_pkg.sv =====
// Package for the sparse row matrix-vector multiply core.
// Holds the shared widths, function codes and the control and result structs.
// Depends on nothing; every other file refers to it by scoped names.
package srmv_pkg;

  // Depth of the dense vector store.
  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
  // Wide enough to hold any position and any legal depth for comparisons.
  localparam int DEPTH_CMP_W  = 17;

  localparam int POS_W       = 10;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 11;
  localparam int ROW_W       = 16;
  localparam int ACC_W       = 64;
  localparam int FRAC_W      = 16;
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_VECTOR_LENGTH = 1'd0;

  localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NONZERO = 2'd1,
    FUNC_EMPTY   = 2'd2
  } func_t;

  // Control that travels alongside one request through the pipeline.
  typedef struct packed {
    logic  valid;
    func_t kind;
    logic  col_err;
    logic  last;
  } item_ctrl_t;

  // Finished row as presented to the output register.
  typedef struct packed {
    logic                       emit;
    logic [ROW_W-1:0]           row_index;
    logic signed [VALUE_W-1:0]  row_value;
    logic                       index_error;
    logic                       saturated;
  } row_result_t;

endpackage

// ===== hdl/srmv_mac.sv =====
// Multiply-accumulate datapath of the sparse row matrix-vector multiply core.
// Registers the product, accumulates rows with saturation and clamps results.
// Depends on srmv_pkg.
module srmv_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  srmv_pkg::item_ctrl_t                 ctrl,
  input  logic signed [srmv_pkg::VALUE_W-1:0]  mat_value,
  input  logic signed [srmv_pkg::VALUE_W-1:0]  vec_value,
  output srmv_pkg::row_result_t                res
);

  // Multiply stage.
  srmv_pkg::item_ctrl_t              s2_ctrl_r;
  logic signed [srmv_pkg::ACC_W-1:0] prod_r;

  // Accumulate stage and row state.
  logic signed [srmv_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                              row_err_r, row_err_nxt;
  logic                              fresh_r, fresh_nxt;
  logic [srmv_pkg::ROW_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic                              s3_emit_r, s3_emit_nxt;
  logic [srmv_pkg::ROW_W-1:0]        s3_row_r, s3_row_nxt;

  logic signed [srmv_pkg::ACC_W-1:0] base;
  logic                              err_base;
  logic signed [srmv_pkg::ACC_W-1:0] term;
  logic signed [srmv_pkg::ACC_W:0]   sum;
  logic signed [srmv_pkg::ACC_W-1:0] sat_sum;

  always_comb begin
    // A row that was just closed or restarted begins from zero.
    base     = fresh_r ? '0 : acc_r;
    err_base = fresh_r ? 1'b0 : row_err_r;
    // Floor division by 2^16 is an arithmetic shift.
    term     = prod_r >>> srmv_pkg::FRAC_W;
    sum      = {base[srmv_pkg::ACC_W-1], base} + {term[srmv_pkg::ACC_W-1], term};
    if (sum[srmv_pkg::ACC_W] != sum[srmv_pkg::ACC_W-1]) begin
      sat_sum = {sum[srmv_pkg::ACC_W], {(srmv_pkg::ACC_W-1){~sum[srmv_pkg::ACC_W]}}};
    end else begin
      sat_sum = sum[srmv_pkg::ACC_W-1:0];
    end

    acc_nxt     = acc_r;
    row_err_nxt = row_err_r;
    fresh_nxt   = fresh_r;
    row_cnt_nxt = row_cnt_r;
    s3_emit_nxt = 1'b0;
    s3_row_nxt  = row_cnt_r;

    if (s2_ctrl_r.valid) begin
      case (s2_ctrl_r.kind)
        srmv_pkg::FUNC_LOAD: begin
          fresh_nxt   = 1'b1;
          row_cnt_nxt = '0;
        end
        srmv_pkg::FUNC_NONZERO: begin
          acc_nxt     = s2_ctrl_r.col_err ? base : sat_sum;
          row_err_nxt = err_base | s2_ctrl_r.col_err;
          fresh_nxt   = s2_ctrl_r.last;
          s3_emit_nxt = s2_ctrl_r.last;
        end
        srmv_pkg::FUNC_EMPTY: begin
          acc_nxt     = base;
          row_err_nxt = err_base;
          fresh_nxt   = 1'b1;
          s3_emit_nxt = 1'b1;
        end
        default: begin
          // Unused code: no change of state.
        end
      endcase
      if (s3_emit_nxt) begin
        row_cnt_nxt = row_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r <= '0;
      fresh_r   <= 1'b1;
      row_err_r <= 1'b0;
      row_cnt_r <= '0;
      s3_emit_r <= 1'b0;
    end else if (adv) begin
      s2_ctrl_r <= ctrl;
      fresh_r   <= fresh_nxt;
      row_err_r <= row_err_nxt;
      row_cnt_r <= row_cnt_nxt;
      s3_emit_r <= s3_emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= mat_value * vec_value;
      acc_r    <= acc_nxt;
      s3_row_r <= s3_row_nxt;
    end
  end

  // Clamp the finished row to Q16.16 range.
  always_comb begin
    res.emit        = s3_emit_r;
    res.row_index   = s3_row_r;
    res.index_error = row_err_r;
    if (acc_r > 64'(srmv_pkg::Q_MAX)) begin
      res.row_value = srmv_pkg::Q_MAX;
      res.saturated = 1'b1;
    end else if (acc_r < 64'(srmv_pkg::Q_MIN)) begin
      res.row_value = srmv_pkg::Q_MIN;
      res.saturated = 1'b1;
    end else begin
      res.row_value = acc_r[srmv_pkg::VALUE_W-1:0];
      res.saturated = 1'b0;
    end
  end

endmodule

// ===== hdl/sparse_row_matrix_vector_multiply_core.sv =====
// Top level of the sparse row matrix-vector multiply core (y = A*x, CSR order).
// Holds the vector store, the input stage, the output register and the
// configuration port. Depends on srmv_pkg and srmv_mac.
//
//   Channel   Direction  Handshake        Contents
//   in_       request    tvalid/tready    tuser func, tdata position+value, tlast row end
//   out_      result     tvalid/tready    tdata row index, row value, error, saturated
//   cfg_      config     APB write/read   vector_length at byte address 0
//
// One request is accepted every cycle unless the pipeline is stopped. A finished
// row reaches the output register after its closing request has passed the
// vector store read, the 32x32 product and the accumulate stage.
// The pipeline stops only when a finished row sits in the accumulate stage and
// the output register still holds an earlier row that has not been taken.
// Reset (rst_n low at a clock edge) clears control state; the vector store is
// not cleared, and a column must be loaded before it is used.
module sparse_row_matrix_vector_multiply_core (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [9:0] position, [41:10] value, [47:42] zero
  input  logic [srmv_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] func
  input  logic [srmv_pkg::FUNC_W-1:0]          in_tuser,
  input  logic                                 in_tlast,

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] row_index, [47:16] row_value, [48] index_error, [49] saturated,
  // [55:50] zero
  output logic [srmv_pkg::OUT_TDATA_W-1:0]     out_tdata,

  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [srmv_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [srmv_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [srmv_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);

  // Configuration register.
  logic [srmv_pkg::LEN_W-1:0] vlen_r;
  logic                       cfg_wr;
  logic [0:0]                 cfg_idx;

  // Input decode.
  logic [srmv_pkg::POS_W-1:0]           in_pos;
  logic signed [srmv_pkg::VALUE_W-1:0]  in_value;
  srmv_pkg::func_t                      in_func;
  logic [srmv_pkg::DEPTH_CMP_W-1:0]     pos_ext;
  logic                                 in_depth;
  logic [srmv_pkg::VEC_AW-1:0]          vec_addr;
  logic                                 accept;
  logic                                 adv;
  srmv_pkg::item_ctrl_t                 in_ctrl;

  // Read stage.
  srmv_pkg::item_ctrl_t                 s1_ctrl_r;
  logic signed [srmv_pkg::VALUE_W-1:0]  s1_value_r;
  logic signed [srmv_pkg::VALUE_W-1:0]  rdata_r;

  logic signed [srmv_pkg::VALUE_W-1:0]  vec_mem [srmv_pkg::VECTOR_DEPTH];

  srmv_pkg::row_result_t                mac_res;

  // Output register.
  logic                                 out_valid_r;
  logic [srmv_pkg::OUT_TDATA_W-1:0]     out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      srmv_pkg::REG_VECTOR_LENGTH: cfg_prdata = {{(srmv_pkg::CFG_DW-srmv_pkg::LEN_W){1'b0}}, vlen_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= srmv_pkg::LEN_RESET;
    end else if (cfg_wr && cfg_idx == srmv_pkg::REG_VECTOR_LENGTH) begin
      vlen_r <= cfg_pwdata[srmv_pkg::LEN_W-1:0];
    end
  end

  // The whole pipeline advances unless a finished row would overwrite an
  // output that is still waiting.
  assign adv       = !(out_valid_r && !out_tready && mac_res.emit);
  assign in_tready = adv;
  assign accept    = in_tvalid & adv;

  assign in_pos   = in_tdata[srmv_pkg::POS_W-1:0];
  assign in_value = in_tdata[srmv_pkg::POS_W +: srmv_pkg::VALUE_W];
  assign in_func  = srmv_pkg::func_t'(in_tuser);
  assign pos_ext  = {{(srmv_pkg::DEPTH_CMP_W-srmv_pkg::POS_W){1'b0}}, in_pos};
  assign in_depth = pos_ext < srmv_pkg::DEPTH_CMP_W'(srmv_pkg::VECTOR_DEPTH);
  assign vec_addr = pos_ext[srmv_pkg::VEC_AW-1:0];

  always_comb begin
    in_ctrl.valid   = in_tvalid;
    in_ctrl.kind    = in_func;
    // Columns at or beyond the configured length, or beyond the store, are errors.
    in_ctrl.col_err = ({1'b0, in_pos} >= vlen_r) || !in_depth;
    in_ctrl.last    = in_tlast;
  end

  // Vector store: written by loads, read for every accepted request. A load
  // and a later nonzero never share an edge, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (accept && in_func == srmv_pkg::FUNC_LOAD && in_depth) begin
      vec_mem[vec_addr] <= in_value;
    end
    if (adv) begin
      rdata_r <= vec_mem[vec_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_value_r <= in_value;
    end
  end

  srmv_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctrl      (s1_ctrl_r),
    .mat_value (s1_value_r),
    .vec_value (rdata_r),
    .res       (mac_res)
  );

  // Output register: loads a finished row, otherwise drains when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && mac_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mac_res.emit) begin
      out_data_r <= {6'b0, mac_res.saturated, mac_res.index_error,
                     mac_res.row_value, mac_res.row_index};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A finished row that moves on always lands in the output register.
  a_row_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mac_res.emit) |=> out_valid_r)
    else $error("finished row was not captured by the output register");

  // A clipped row carries one of the two range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[49]) |->
      (out_data_r[47:16] == srmv_pkg::Q_MAX || out_data_r[47:16] == srmv_pkg::Q_MIN))
    else $error("saturated row does not hold a range limit");

  // While the pipeline is stopped the pending row does not change.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |=> $stable(mac_res))
    else $error("pending row changed while the pipeline was stopped");
`endif

endmodule
